// ===== sv/hot_pkg.sv =====
// ---------------------------------------------------------------------------
// hot_pkg
// shared types and constants of the hop offset sync tracker
// ---------------------------------------------------------------------------
package hot_pkg;

   localparam int CHANNELS     = 52;
   localparam int CHAN_W       = 6;
   localparam int ADDR_W       = $clog2(CHANNELS);
   localparam int OFFSET_WIDTH = 18;
   localparam int MEAS_W       = 16;
   localparam int OUT_OFF_W    = 18;
   localparam int MISS_W       = 4;
   localparam int CB_W         = 4;
   localparam int CBL_W        = 4;
   localparam int CHL_W        = 3;
   localparam int COUNT_W      = 16;
   localparam int PADDR_W      = 3;
   localparam int PDATA_W      = 32;

   localparam logic [CBL_W-1:0] CB_LIMIT_RESET = 4'd5;
   localparam logic [CHL_W-1:0] CH_LIMIT_RESET = 3'd3;

   typedef enum logic [1:0] {
      MODE_GOOD = 2'd0,
      MODE_BAD  = 2'd1,
      MODE_SYNC = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic {
      REG_CB_LIMIT = 1'b0,
      REG_CH_LIMIT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_CUR,
      ST_UPDATE,
      ST_READ_OUT,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic signed [OFFSET_WIDTH-1:0] offset;
      logic [MISS_W-1:0]              miss;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic read;
      logic update;
      logic load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== sv/hot_ram.sv =====
// ---------------------------------------------------------------------------
// hot_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module hot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/hot_ctrl.sv =====
// ---------------------------------------------------------------------------
// hot_ctrl
// sequencer: read entry, update, read result entry, load output
// ---------------------------------------------------------------------------
module hot_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hot_pkg::status_type status,
   output hot_pkg::cmd_type    cmd
);

   hot_pkg::state_type state_ff;
   hot_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hot_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hot_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = hot_pkg::ST_READ_CUR;
            end
         end
         hot_pkg::ST_READ_CUR: begin
            cmd.read = 1'b1;
            state_in = hot_pkg::ST_UPDATE;
         end
         hot_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = hot_pkg::ST_READ_OUT;
         end
         hot_pkg::ST_READ_OUT: begin
            cmd.read = 1'b1;
            state_in = hot_pkg::ST_LOAD;
         end
         hot_pkg::ST_LOAD: begin
            // hold until the output register can take the word
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = hot_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hot_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/hot_datapath.sv =====
// ---------------------------------------------------------------------------
// hot_datapath
// tracker state, channel table, offset update and output register
// ---------------------------------------------------------------------------
module hot_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hot_pkg::cmd_type                     cmd,
   output hot_pkg::status_type                  status,
   input  logic [1:0]                           req_mode,
   input  logic signed [hot_pkg::MEAS_W-1:0]    req_measured_offset,
   input  logic [hot_pkg::CHAN_W-1:0]           req_next_channel,
   input  logic [hot_pkg::CHAN_W-1:0]           req_random_channel,
   input  logic [hot_pkg::CBL_W-1:0]            cb_limit,
   input  logic [hot_pkg::CHL_W-1:0]            ch_limit,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hot_pkg::CHAN_W-1:0]           rsp_tune_channel,
   output logic signed [hot_pkg::OUT_OFF_W-1:0] rsp_tune_offset,
   output logic                                 rsp_dwell_start,
   output logic                                 rsp_sync_timer_start,
   output logic                                 rsp_sync_timer_stop,
   output logic                                 rsp_lost_sync,
   output logic                                 rsp_synced,
   output logic [hot_pkg::COUNT_W-1:0]          rsp_packet_count
);

   localparam int W = hot_pkg::OFFSET_WIDTH;

   // latched word
   hot_pkg::mode_type                mode_ff;
   logic signed [hot_pkg::MEAS_W-1:0] meas_ff;
   logic [hot_pkg::ADDR_W-1:0]       nxt_ff;
   logic [hot_pkg::ADDR_W-1:0]       rnd_ff;

   // tracker state
   logic [hot_pkg::ADDR_W-1:0]  cur_ff, cur_in;
   logic [hot_pkg::CB_W-1:0]    cb_ff, cb_in;
   logic [hot_pkg::COUNT_W-1:0] good_ff, good_in;
   logic                        ever_ff, ever_in;
   logic [hot_pkg::CHANNELS-1:0] valid_ff;

   // strobes waiting for the output load
   logic dwell_ff, dwell_in;
   logic sstart_ff, sstart_in;
   logic sstop_ff, sstop_in;
   logic lost_ff, lost_in;

   // output register
   logic                                 rsp_valid_ff;
   logic [hot_pkg::CHAN_W-1:0]           tune_channel_ff;
   logic signed [hot_pkg::OUT_OFF_W-1:0] tune_offset_ff;
   logic                                 dwell_out_ff, sstart_out_ff, sstop_out_ff;
   logic                                 lost_out_ff, synced_out_ff;
   logic [hot_pkg::COUNT_W-1:0]          count_out_ff;

   // table access
   hot_pkg::entry_type ram_rdata, entry_cur, entry_in;
   logic               wr_in;

   logic signed [W:0]          sum;
   logic signed [W-1:0]        sat_off;
   logic [hot_pkg::CB_W-1:0]   cb_inc;
   logic [hot_pkg::MISS_W-1:0] miss_inc;
   logic [hot_pkg::ADDR_W-1:0] cur_mid;
   logic                       hop_en;

   // reduce a 6-bit channel below CHANNELS, one subtract covers CHANNELS above 32
   function automatic logic [hot_pkg::ADDR_W-1:0] chan_of(input logic [hot_pkg::CHAN_W-1:0] v);
      logic [hot_pkg::CHAN_W-1:0] r;
      begin
         r = v;
         if (v >= hot_pkg::CHAN_W'(hot_pkg::CHANNELS)) begin
            r = v - hot_pkg::CHAN_W'(hot_pkg::CHANNELS);
         end
         chan_of = hot_pkg::ADDR_W'(r);
      end
   endfunction

   hot_ram #(
      .WIDTH(hot_pkg::ENTRY_W),
      .DEPTH(hot_pkg::CHANNELS)
   ) u_table (
      .clock(clock),
      .we   (cmd.update & wr_in),
      .re   (cmd.read),
      .addr (cur_ff),
      .wdata(entry_in),
      .rdata(ram_rdata)
   );

   // entries never written since reset or since sync loss read as zero
   assign entry_cur = valid_ff[cur_ff] ? ram_rdata : '0;

   always_comb begin
      sum = (W+1)'(signed'(meas_ff)) + (W+1)'(signed'(entry_cur.offset));
      if (sum[W] != sum[W-1]) begin
         sat_off = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         sat_off = sum[W-1:0];
      end
   end

   assign cb_inc   = (cb_ff == '1) ? cb_ff : cb_ff + 1'b1;
   assign miss_inc = (entry_cur.miss == '1) ? entry_cur.miss : entry_cur.miss + 1'b1;

   always_comb begin
      cb_in     = cb_ff;
      good_in   = good_ff;
      ever_in   = ever_ff;
      entry_in  = entry_cur;
      wr_in     = 1'b0;
      cur_mid   = cur_ff;
      hop_en    = 1'b1;
      sstart_in = 1'b0;
      sstop_in  = 1'b0;
      lost_in   = 1'b0;
      case (mode_ff)
         hot_pkg::MODE_GOOD: begin
            sstop_in        = 1'b1;
            cb_in           = '0;
            good_in         = good_ff + 1'b1;
            ever_in         = 1'b1;
            entry_in.offset = sat_off;
            entry_in.miss   = '0;
            wr_in           = 1'b1;
         end
         hot_pkg::MODE_BAD: begin
            cb_in = cb_inc;
            if (miss_inc > {1'b0, ch_limit}) begin
               entry_in = '0;
            end else begin
               entry_in.miss = miss_inc;
            end
            wr_in = 1'b1;
            if (cb_inc == cb_limit) begin
               // sync lost: table cleared through the valid bits
               lost_in   = 1'b1;
               sstart_in = 1'b1;
               wr_in     = 1'b0;
               cur_mid   = rnd_ff;
            end
         end
         hot_pkg::MODE_SYNC: begin
            cur_mid   = rnd_ff;
            sstart_in = 1'b1;
         end
         default: begin
            hop_en = 1'b0;
         end
      endcase
      dwell_in = hop_en && (cb_in < cb_limit);
      cur_in   = dwell_in ? nxt_ff : cur_mid;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= hot_pkg::mode_type'(req_mode);
         meas_ff <= req_measured_offset;
         nxt_ff  <= chan_of(req_next_channel);
         rnd_ff  <= chan_of(req_random_channel);
      end
      if (cmd.update) begin
         dwell_ff  <= dwell_in;
         sstart_ff <= sstart_in;
         sstop_ff  <= sstop_in;
         lost_ff   <= lost_in;
      end
      if (cmd.load) begin
         tune_channel_ff <= hot_pkg::CHAN_W'(cur_ff);
         tune_offset_ff  <= hot_pkg::OUT_OFF_W'(entry_cur.offset);
         dwell_out_ff    <= dwell_ff;
         sstart_out_ff   <= sstart_ff;
         sstop_out_ff    <= sstop_ff;
         lost_out_ff     <= lost_ff;
         synced_out_ff   <= (cb_ff < cb_limit) && ever_ff;
         count_out_ff    <= good_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         cb_ff        <= '0;
         good_ff      <= '0;
         ever_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            cur_ff  <= cur_in;
            cb_ff   <= cb_in;
            good_ff <= good_in;
            ever_ff <= ever_in;
            if (lost_in) begin
               valid_ff <= '0;
            end else if (wr_in) begin
               valid_ff[cur_ff] <= 1'b1;
            end
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_tune_channel     = tune_channel_ff;
   assign rsp_tune_offset      = tune_offset_ff;
   assign rsp_dwell_start      = dwell_out_ff;
   assign rsp_sync_timer_start = sstart_out_ff;
   assign rsp_sync_timer_stop  = sstop_out_ff;
   assign rsp_lost_sync        = lost_out_ff;
   assign rsp_synced           = synced_out_ff;
   assign rsp_packet_count     = count_out_ff;

endmodule

// ===== sv/hop_offset_sync_tracker.sv =====
// ---------------------------------------------------------------------------
// hop_offset_sync_tracker
// sync tracker for a frequency-hopping receiver, one result word per event
// ---------------------------------------------------------------------------
// event words: the next one is accepted only after the result word of the last
//   is loaded, after two registered reads of the single-port channel table
//   (entry of the old, then the new channel) and a wait for a free output slot
// reset: synchronous; counters, channel and limits return to reset values and
//   per-channel valid bits clear the table at once, no clearing pass
// ---------------------------------------------------------------------------
module hop_offset_sync_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   // event words
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic signed [hot_pkg::MEAS_W-1:0]    req_measured_offset,
   input  logic [hot_pkg::CHAN_W-1:0]           req_next_channel,
   input  logic [hot_pkg::CHAN_W-1:0]           req_random_channel,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hot_pkg::CHAN_W-1:0]           rsp_tune_channel,
   output logic signed [hot_pkg::OUT_OFF_W-1:0] rsp_tune_offset,
   output logic                                 rsp_dwell_start,
   output logic                                 rsp_sync_timer_start,
   output logic                                 rsp_sync_timer_stop,
   output logic                                 rsp_lost_sync,
   output logic                                 rsp_synced,
   output logic [hot_pkg::COUNT_W-1:0]          rsp_packet_count,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [hot_pkg::PADDR_W-1:0]          paddr,
   input  logic [hot_pkg::PDATA_W-1:0]          pwdata,
   output logic [hot_pkg::PDATA_W-1:0]          prdata,
   output logic                                 pready
);

   hot_pkg::cmd_type    cmd;
   hot_pkg::status_type status;

   // limit registers
   logic [hot_pkg::CBL_W-1:0] cb_limit_ff;
   logic [hot_pkg::CHL_W-1:0] ch_limit_ff;
   logic                      csr_write;
   hot_pkg::reg_index_type    csr_index;

   // word-aligned decode, register index sits in address bit 2
   assign csr_index = hot_pkg::reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_limit_ff <= hot_pkg::CB_LIMIT_RESET;
         ch_limit_ff <= hot_pkg::CH_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            hot_pkg::REG_CB_LIMIT: cb_limit_ff <= pwdata[hot_pkg::CBL_W-1:0];
            hot_pkg::REG_CH_LIMIT: ch_limit_ff <= pwdata[hot_pkg::CHL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         hot_pkg::REG_CB_LIMIT: prdata = hot_pkg::PDATA_W'(cb_limit_ff);
         hot_pkg::REG_CH_LIMIT: prdata = hot_pkg::PDATA_W'(ch_limit_ff);
         default:               prdata = '0;
      endcase
   end

   // sequencer: accept, read old entry, update, read new entry, load output
   hot_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // state, channel table and output register
   hot_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_mode),
      .req_measured_offset (req_measured_offset),
      .req_next_channel    (req_next_channel),
      .req_random_channel  (req_random_channel),
      .cb_limit            (cb_limit_ff),
      .ch_limit            (ch_limit_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tune_channel    (rsp_tune_channel),
      .rsp_tune_offset     (rsp_tune_offset),
      .rsp_dwell_start     (rsp_dwell_start),
      .rsp_sync_timer_start(rsp_sync_timer_start),
      .rsp_sync_timer_stop (rsp_sync_timer_stop),
      .rsp_lost_sync       (rsp_lost_sync),
      .rsp_synced          (rsp_synced),
      .rsp_packet_count    (rsp_packet_count)
   );

endmodule
